// ----- rtl/smn_pkg.sv -----
// smn_pkg: shared types and constants for the min-max normalizer with smoothing.
// No dependencies; imported by the top level.
package smn_pkg;

    // default sizing
    localparam int NUM_CHANNELS_DEF    = 6;
    localparam int SAMPLE_BITS_DEF     = 12;
    localparam int ALPHA_FRAC_BITS_DEF = 8;

    // field widths fixed by the stream format
    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 12;
    localparam int FS_W     = 16;
    localparam int ALPHA_W  = 9;
    localparam int NORM_W   = 16;
    localparam int SMOOTH_W = 16;

    localparam int IN_TDATA_W  = 16;   // channel + sample, padded to bytes
    localparam int OUT_TDATA_W = 40;   // channel + normalized + smoothed, padded
    localparam int OUT_PAD_W   = OUT_TDATA_W - CHAN_W - NORM_W - SMOOTH_W;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 2'd2;

    localparam logic [FS_W-1:0]    FULL_SCALE_RST = 16'd1000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST      = 9'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

endpackage

// ----- rtl/smn_ram.sv -----
// smn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module smn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/smn_div.sv -----
// smn_div: iterative restoring divider, two quotient bits per cycle.
// No dependencies; used by the top level for the span division.
module smn_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int STEPS = (NUM_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [PAD_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // two dependent compare-subtract steps per cycle
    always_comb begin
        logic [DEN_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[PAD_W-1]};
            n_quo = {n_quo[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial    = trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= PAD_W'(i_num);
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[NUM_W-1:0];

endmodule

// ----- rtl/sensor_minmax_normalize_smooth.sv -----
// Per-channel min-max normalizer with exponential smoothing. One input word is
// taken at a time. A calibration word updates the channel's running min and max
// and yields nothing (RAM read on acceptance, update and write-back in the load
// state), and a dropped word is consumed in the idle state. A run word goes
// through the load, divide, multiply and output states; the span division in the
// radix-4 iterative divider is its longest step, and the next word is taken
// once the output word is loaded. The division is skipped when the span is not
// positive or the sample is at or above the channel maximum. A run word whose
// result finds the output register still full waits in its last stage until the
// word ahead is taken. Per-channel state (min, max, smoothed value) lives in one
// RAM with a valid bit per channel, so it reads as its reset value until first
// written; no clearing pass is needed. The output word sits in a register, so
// the next input word is accepted while a result waits. Channels at or above
// NUM_CHANNELS are dropped.
module sensor_minmax_normalize_smooth #(
    parameter int NUM_CHANNELS    = smn_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS     = smn_pkg::SAMPLE_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = smn_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [smn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [smn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [smn_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // channel[2:0], sample[14:3]
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [smn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_channel[2:0],
                                                           // normalized[18:3],
                                                           // smoothed[34:19]
    output logic                            m_axis_tuser   // span_invalid
);

    import smn_pkg::*;

    localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SB     = SAMPLE_BITS;
    localparam int WORD_W = 2 * SB + SMOOTH_W;
    localparam int NUM_W  = FS_W + SB;
    localparam int A_W    = (ALPHA_FRAC_BITS + 1 > ALPHA_W) ? ALPHA_FRAC_BITS + 1 : ALPHA_W;
    localparam int PR_W   = A_W + SMOOTH_W;
    localparam logic [A_W-1:0] ONE = A_W'(1) << ALPHA_FRAC_BITS;

    // configuration
    logic                r_cal;
    logic [FS_W-1:0]     r_fs;
    logic [ALPHA_W-1:0]  r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal   <= 1'b0;
            r_fs    <= FULL_SCALE_RST;
            r_alpha <= ALPHA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CALIBRATE:  r_cal   <= i_cfg_data[0];
                CFG_FULL_SCALE: r_fs    <= i_cfg_data;
                CFG_ALPHA:      r_alpha <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // input decode
    logic [CHAN_W-1:0]   in_ch;
    logic [SAMPLE_W-1:0] in_sample;
    logic                in_range;
    logic [AW-1:0]       in_addr;

    assign in_ch     = s_axis_tdata[CHAN_W-1:0];
    assign in_sample = s_axis_tdata[CHAN_W +: SAMPLE_W];
    assign in_range  = (32'(in_ch) < NUM_CHANNELS);
    assign in_addr   = AW'(in_ch);

    t_state r_state, n_state;

    logic                in_acc;
    logic                ram_we;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;
    logic                out_load;

    // per-item registers
    logic [AW-1:0]       r_addr;
    logic [CHAN_W-1:0]   r_ch;
    logic [SB-1:0]       r_s;
    logic                r_rd_vld;
    logic [SB-1:0]       r_min, r_max;
    logic [SMOOTH_W-1:0] r_old;
    logic                r_bad;
    logic [NORM_W-1:0]   r_norm;
    logic [PR_W-1:0]     r_p1, r_p2;
    logic [NUM_CHANNELS-1:0] r_ent_vld;

    // entry decode, reset values for entries never written
    logic [SB-1:0]       ent_min, ent_max, s_c, new_min, new_max;
    logic [SMOOTH_W-1:0] ent_sm, new_sm;
    logic                bad, sat;
    logic [SB-1:0]       span;
    logic [NUM_W-1:0]    num;
    logic [A_W-1:0]      a_eff, alpha_ext;
    logic [PR_W:0]       sum;

    assign ent_min = r_rd_vld ? ram_rdata[SB-1:0]                 : '1;
    assign ent_max = r_rd_vld ? ram_rdata[2*SB-1:SB]              : '0;
    assign ent_sm  = r_rd_vld ? ram_rdata[2*SB +: SMOOTH_W]       : '0;

    assign new_min = (r_s < ent_min) ? r_s : ent_min;
    assign new_max = (r_s > ent_max) ? r_s : ent_max;

    assign s_c  = (r_s < ent_min) ? ent_min : r_s;
    assign bad  = (ent_max <= ent_min);
    assign sat  = (s_c >= ent_max);
    assign span = ent_max - ent_min;
    assign num  = NUM_W'(r_fs) * NUM_W'(s_c - ent_min);

    assign alpha_ext = A_W'(r_alpha);
    assign a_eff     = (alpha_ext > ONE) ? ONE : alpha_ext;
    assign sum       = (PR_W + 1)'(r_p1) + (PR_W + 1)'(r_p2);
    assign new_sm    = SMOOTH_W'(sum >> ALPHA_FRAC_BITS);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid && in_range) n_state = S_LOAD;
            S_LOAD: begin
                if (r_cal)           n_state = S_IDLE;
                else if (bad || sat) n_state = S_MUL;
                else                 n_state = S_DIV;
            end
            S_DIV:  if (div_done) n_state = S_MUL;
            S_MUL:  n_state = S_OUT;
            S_OUT:  if (!m_axis_tvalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        ram_wdata     = {ent_sm, new_max, new_min};
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_LOAD: begin
                ram_we    = r_cal;
                div_start = !r_cal && !bad && !sat;
            end
            S_DIV, S_MUL: ;
            S_OUT: begin
                out_load  = !m_axis_tvalid || m_axis_tready;
                ram_we    = out_load;
                ram_wdata = {new_sm, r_max, r_min};
            end
            default: ;
        endcase
    end

    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ent_vld <= '0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_ent_vld[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr   <= in_addr;
            r_ch     <= in_ch;
            r_s      <= SB'(in_sample);
            r_rd_vld <= in_range && r_ent_vld[in_addr];
        end
        if (r_state == S_LOAD) begin
            r_min  <= ent_min;
            r_max  <= ent_max;
            r_old  <= ent_sm;
            r_bad  <= bad;
            r_norm <= bad ? '0 : r_fs;
        end
        if (r_state == S_DIV && div_done) begin
            r_norm <= div_quo[NORM_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_p1 <= PR_W'(a_eff) * PR_W'(r_norm);
            r_p2 <= PR_W'(ONE - a_eff) * PR_W'(r_old);
        end
    end

    smn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    smn_div #(
        .NUM_W (NUM_W),
        .DEN_W (SB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (span),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // output register
    logic                r_m_valid;
    logic [CHAN_W-1:0]   r_m_ch;
    logic [NORM_W-1:0]   r_m_norm;
    logic [SMOOTH_W-1:0] r_m_sm;
    logic                r_m_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_ch   <= r_ch;
            r_m_norm <= r_norm;
            r_m_sm   <= new_sm;
            r_m_bad  <= r_bad;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_m_sm, r_m_norm, r_m_ch};
    assign m_axis_tuser  = r_m_bad;

    // checks
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output word overwritten while held");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_LOAD || r_state == S_OUT))
        else $error("state RAM written from wrong state");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_m_norm == '0))
        else $error("invalid span with nonzero normalized value");

    a_cal_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_cal) |=> !out_load)
        else $error("calibration word produced a result");

endmodule
